// ===== rtl/lrfs_pkg.sv =====
// ---------------------------------------------------------------------------
// lrfs_pkg
// Shared types, constants, microcode table and channel math for the LED
// rainbow fade sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package lrfs_pkg;

  localparam int NUM_LEDS_DEF = 4;

  localparam int          CHAN_W        = 8;
  localparam int          PH_W          = 3;
  localparam int          COL_W         = 3 * CHAN_W;
  localparam int          IDX_W         = 6;
  localparam logic [7:0]  CHAN_MAX      = 8'hFF;
  localparam logic [7:0]  FADE_STEP_RST = 8'd5;

  // fade phases
  localparam logic [2:0] PH_WHITE     = 3'd0;
  localparam logic [2:0] PH_RED       = 3'd1;
  localparam logic [2:0] PH_YELLOW    = 3'd2;
  localparam logic [2:0] PH_GREEN     = 3'd3;
  localparam logic [2:0] PH_TURQUOISE = 3'd4;
  localparam logic [2:0] PH_BLUE      = 3'd5;
  localparam logic [2:0] PH_INDIGO    = 3'd6;

  // microcode program steps
  localparam int         PC_W      = 2;
  localparam logic [1:0] STEP_IDLE = 2'd0;
  localparam logic [1:0] STEP_READ = 2'd1;
  localparam logic [1:0] STEP_UPD  = 2'd2;
  localparam logic [1:0] STEP_NEXT = 2'd3;

  // jump conditions
  localparam logic [1:0] COND_NONE     = 2'd0;
  localparam logic [1:0] COND_NO_IN    = 2'd1;
  localparam logic [1:0] COND_OUT_BUSY = 2'd2;
  localparam logic [1:0] COND_NOT_LAST = 2'd3;

  typedef struct packed {
    logic       take_in;  // input channel open
    logic       rd;       // read LED stores at current index
    logic       upd;      // compute, write back, load result register
    logic       nxt;      // advance LED index
    logic [1:0] cond;     // jump condition
    logic [1:0] tgt;      // jump target
  } ctrl_t;

  typedef struct packed {
    logic out_busy;  // result register full and stalled
    logic led_last;  // current LED is the final one
  } stat_t;

  // control store
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    cw = '0;
    unique case (pc)
      STEP_IDLE: begin
        cw.take_in = 1'b1;
        cw.cond    = COND_NO_IN;
        cw.tgt     = STEP_IDLE;
      end
      STEP_READ: begin
        cw.rd   = 1'b1;
        cw.cond = COND_NONE;
        cw.tgt  = STEP_IDLE;
      end
      STEP_UPD: begin
        cw.upd  = 1'b1;
        cw.cond = COND_OUT_BUSY;
        cw.tgt  = STEP_UPD;
      end
      STEP_NEXT: begin
        // falls through to idle (wraps) after the last LED
        cw.nxt  = 1'b1;
        cw.cond = COND_NOT_LAST;
        cw.tgt  = STEP_READ;
      end
      default: begin
        cw = '0;
      end
    endcase
    return cw;
  endfunction

  // target corner, red in the top byte
  function automatic logic [COL_W-1:0] corner(input logic [PH_W-1:0] ph);
    logic [COL_W-1:0] c;
    c = '0;
    unique case (ph)
      PH_WHITE:     c = {CHAN_MAX, CHAN_MAX, CHAN_MAX};
      PH_RED:       c = {CHAN_MAX, 8'h00,    8'h00};
      PH_YELLOW:    c = {CHAN_MAX, CHAN_MAX, 8'h00};
      PH_GREEN:     c = {8'h00,    CHAN_MAX, 8'h00};
      PH_TURQUOISE: c = {8'h00,    CHAN_MAX, CHAN_MAX};
      PH_BLUE:      c = {8'h00,    8'h00,    CHAN_MAX};
      PH_INDIGO:    c = {CHAN_MAX, 8'h00,    CHAN_MAX};
      default:      c = '0;
    endcase
    return c;
  endfunction

  // one channel toward 0 or full scale, saturating
  function automatic logic [CHAN_W-1:0] move_chan(input logic [CHAN_W-1:0] lvl,
                                                  input logic              up,
                                                  input logic [CHAN_W-1:0] step);
    logic [CHAN_W:0] sum;
    logic [CHAN_W-1:0] res;
    sum = {1'b0, lvl} + {1'b0, step};
    if (up) begin
      res = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
    end else begin
      res = (lvl > step) ? (lvl - step) : '0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/led_rainbow_fade_sequencer_unit.sv =====
// ---------------------------------------------------------------------------
// led_rainbow_fade_sequencer_unit
// Per-tick rainbow fade of a string of LEDs, one colour result per LED.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall / in_restart): one transaction is one
//    update tick. in_restart = 1 clears all colours and sets each LED's phase
//    to its index mod 7 before the tick is applied.
//  - Result channel (out_valid / out_stall / payload): NUM_LEDS transactions
//    per tick, LED 0 first; out_last marks the final LED.
//  - cfg_wr_en / cfg_fade_step: writes the fade step; only while idle.
// Timing:
//  - A microcoded sequencer runs a 4-step program: idle, read, update, next.
//    Each LED goes through read, update and next on the single-port stores;
//    LED 0's result reaches the result register after its read and update
//    steps, and each tick also spends one idle step.
//  - While out_stall holds the result register full, the update step waits;
//    no result is lost. in_stall stays high until the tick is fully issued.
// Reset: synchronous, active low. Fade step returns to 5, colours read as zero
//  and phases as index mod 7 (per-LED valid bits, no clearing pass).
// ---------------------------------------------------------------------------
`default_nettype none

module led_rainbow_fade_sequencer_unit #(
  parameter int NUM_LEDS = lrfs_pkg::NUM_LEDS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // tick input
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          in_restart,
  // per-LED results
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [lrfs_pkg::IDX_W-1:0]   out_led_index,
  output logic [lrfs_pkg::CHAN_W-1:0]  out_red,
  output logic [lrfs_pkg::CHAN_W-1:0]  out_green,
  output logic [lrfs_pkg::CHAN_W-1:0]  out_blue,
  output logic                         out_last,
  // configuration
  input  wire                          cfg_wr_en,
  input  wire  [lrfs_pkg::CHAN_W-1:0]  cfg_fade_step
);

  lrfs_pkg::ctrl_t ctrl;
  lrfs_pkg::stat_t stat;
  logic            in_accept;

  // input channel opens only on the idle step
  assign in_stall  = !ctrl.take_in;
  assign in_accept = in_valid && !in_stall;

  lrfs_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  lrfs_datapath #(
    .NUM_LEDS (NUM_LEDS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_accept     (in_accept),
    .in_restart    (in_restart),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_fade_step (cfg_fade_step),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_led_index (out_led_index),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_last      (out_last)
  );

`ifndef ASSERT_OFF
  // a tick just taken keeps the input closed while its LEDs are walked
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("input reopened right after a tick transaction");

  // last flag only on the final LED
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_led_index == lrfs_pkg::IDX_W'(NUM_LEDS - 1)))
    else $error("out_last on a non-final LED");

  // index stays within the string
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_led_index} < 7'(NUM_LEDS)))
    else $error("LED index out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/lrfs_useq.sv =====
// ---------------------------------------------------------------------------
// lrfs_useq
// Microcode sequencer: step counter, control store lookup, conditional jumps.
// ---------------------------------------------------------------------------
`default_nettype none

module lrfs_useq (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire lrfs_pkg::stat_t stat,
  output lrfs_pkg::ctrl_t      ctrl
);

  logic [lrfs_pkg::PC_W-1:0] pc_r;
  logic [lrfs_pkg::PC_W-1:0] pc_nxt;
  logic                      jump;

  assign ctrl = lrfs_pkg::ucode(pc_r);

  always_comb begin
    unique case (ctrl.cond)
      lrfs_pkg::COND_NONE:     jump = 1'b0;
      lrfs_pkg::COND_NO_IN:    jump = !in_valid;
      lrfs_pkg::COND_OUT_BUSY: jump = stat.out_busy;
      lrfs_pkg::COND_NOT_LAST: jump = !stat.led_last;
      default:                 jump = 1'b0;
    endcase
    pc_nxt = jump ? ctrl.tgt : lrfs_pkg::PC_W'(pc_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= lrfs_pkg::STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lrfs_datapath.sv =====
// ---------------------------------------------------------------------------
// lrfs_datapath
// LED index, phase and colour stores with valid bits, fade math, result
// register and the fade step register.
// ---------------------------------------------------------------------------
`default_nettype none

module lrfs_datapath #(
  parameter int NUM_LEDS = lrfs_pkg::NUM_LEDS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire lrfs_pkg::ctrl_t               ctrl,
  input  wire                                in_accept,
  input  wire                                in_restart,
  input  wire                                cfg_wr_en,
  input  wire  [lrfs_pkg::CHAN_W-1:0]        cfg_fade_step,
  output lrfs_pkg::stat_t                    stat,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [lrfs_pkg::IDX_W-1:0]         out_led_index,
  output logic [lrfs_pkg::CHAN_W-1:0]        out_red,
  output logic [lrfs_pkg::CHAN_W-1:0]        out_green,
  output logic [lrfs_pkg::CHAN_W-1:0]        out_blue,
  output logic                               out_last
);

  localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int CW    = lrfs_pkg::CHAN_W;

  logic [LED_W-1:0]             led_cnt_r;
  logic [lrfs_pkg::PH_W-1:0]    ph7_r;      // led index mod 7
  logic [NUM_LEDS-1:0]          vld_r;
  logic [CW-1:0]                fade_r;
  logic                         out_valid_r;

  logic [lrfs_pkg::PH_W-1:0]    ph_mem  [NUM_LEDS];
  logic [lrfs_pkg::COL_W-1:0]   col_mem [NUM_LEDS];
  logic [lrfs_pkg::PH_W-1:0]    ph_rd_r;
  logic [lrfs_pkg::COL_W-1:0]   col_rd_r;

  logic                         led_last;
  logic                         out_busy;
  logic                         do_upd;
  logic [lrfs_pkg::PH_W-1:0]    ph_cur;
  logic [lrfs_pkg::COL_W-1:0]   col_cur;
  logic [lrfs_pkg::COL_W-1:0]   tgt;
  logic [lrfs_pkg::PH_W-1:0]    ph_new;
  logic [lrfs_pkg::COL_W-1:0]   col_new;

  assign led_last      = (led_cnt_r == LED_W'(NUM_LEDS - 1));
  assign out_busy      = out_valid_r && out_stall;
  assign do_upd        = ctrl.upd && !out_busy;
  assign stat.out_busy = out_busy;
  assign stat.led_last = led_last;
  assign out_valid     = out_valid_r;

  // entries not written since restart read as their reset value
  always_comb begin
    ph_cur  = vld_r[led_cnt_r] ? ph_rd_r : ph7_r;
    col_cur = vld_r[led_cnt_r] ? col_rd_r : '0;
    tgt     = lrfs_pkg::corner(ph_cur);
    ph_new  = ph_cur;
    col_new = col_cur;
    if (ph_cur > lrfs_pkg::PH_INDIGO) begin
      ph_new = lrfs_pkg::PH_WHITE;
    end else if (col_cur == tgt) begin
      ph_new = (ph_cur == lrfs_pkg::PH_INDIGO) ? lrfs_pkg::PH_WHITE
                                               : lrfs_pkg::PH_W'(ph_cur + 1'b1);
    end else begin
      for (int c = 0; c < 3; c++) begin
        col_new[c*CW +: CW] = lrfs_pkg::move_chan(col_cur[c*CW +: CW],
                                                  tgt[c*CW], fade_r);
      end
    end
  end

  // LED stores
  always_ff @(posedge clk) begin
    if (do_upd) begin
      ph_mem[led_cnt_r]  <= ph_new;
      col_mem[led_cnt_r] <= col_new;
    end
    if (ctrl.rd) begin
      ph_rd_r  <= ph_mem[led_cnt_r];
      col_rd_r <= col_mem[led_cnt_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_cnt_r   <= '0;
      ph7_r       <= lrfs_pkg::PH_WHITE;
      vld_r       <= '0;
      fade_r      <= lrfs_pkg::FADE_STEP_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fade_r <= cfg_fade_step;
      end
      if (in_accept) begin
        led_cnt_r <= '0;
        ph7_r     <= lrfs_pkg::PH_WHITE;
        if (in_restart) begin
          vld_r <= '0;
        end
      end
      if (do_upd) begin
        vld_r[led_cnt_r] <= 1'b1;
      end
      if (ctrl.nxt && !led_last) begin
        led_cnt_r <= LED_W'(led_cnt_r + 1'b1);
        ph7_r     <= (ph7_r == lrfs_pkg::PH_INDIGO) ? lrfs_pkg::PH_WHITE
                                                    : lrfs_pkg::PH_W'(ph7_r + 1'b1);
      end
      if (do_upd) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (do_upd) begin
      out_led_index <= lrfs_pkg::IDX_W'(led_cnt_r);
      out_red       <= col_new[2*CW +: CW];
      out_green     <= col_new[CW +: CW];
      out_blue      <= col_new[0 +: CW];
      out_last      <= led_last;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED rainbow fade sequencer: a directed tick
// table, then random ticks under several fade steps. Every colour transaction
// is checked against an in-bench model of the per-LED phase and levels.
// ---------------------------------------------------------------------------

module tb_top;

  localparam int IDX_W  = lrfs_pkg::IDX_W;
  localparam int CHAN_W = lrfs_pkg::CHAN_W;
  localparam int COL_W  = lrfs_pkg::COL_W;
  localparam int PH_W   = lrfs_pkg::PH_W;

  localparam logic [PH_W-1:0]   PH_WHITE      = lrfs_pkg::PH_WHITE;
  localparam logic [PH_W-1:0]   PH_RED        = lrfs_pkg::PH_RED;
  localparam logic [PH_W-1:0]   PH_YELLOW     = lrfs_pkg::PH_YELLOW;
  localparam logic [PH_W-1:0]   PH_GREEN      = lrfs_pkg::PH_GREEN;
  localparam logic [PH_W-1:0]   PH_TURQUOISE  = lrfs_pkg::PH_TURQUOISE;
  localparam logic [PH_W-1:0]   PH_BLUE       = lrfs_pkg::PH_BLUE;
  localparam logic [PH_W-1:0]   PH_INDIGO     = lrfs_pkg::PH_INDIGO;
  localparam logic [CHAN_W-1:0] FADE_STEP_RST = lrfs_pkg::FADE_STEP_RST;

  localparam int N_LEDS         = 4;
  localparam int DIR_ROWS       = 25;
  localparam int RANDOM_TICKS   = 330;
  localparam int WATCHDOG_LIMIT = 4000;
  // long receiver hold, started once enough colours have come back
  localparam int HOLD_CYCLES    = 120;
  localparam int HOLD_AT_RESULT = 130;
  // read, update and next steps per LED plus the idle step, with some slack
  localparam int DRAIN_CYCLES   = 3 * N_LEDS + 8;

  typedef struct packed {
    logic [IDX_W-1:0]  led;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } led_colour_t;

  // one directed tick; colours holds LED 0 in the top 24 bits, {r,g,b} each
  typedef struct packed {
    bit                       set_step;
    logic [CHAN_W-1:0]        step;
    logic                     restart;
    bit                       typed;
    logic [N_LEDS*COL_W-1:0]  colours;
  } tick_row_t;

  localparam logic [N_LEDS*COL_W-1:0] NO_COLOURS = '0;

  // Typed colours are only given where they follow at a glance: first tick
  // after reset, restart with reset / zero / full / minimum step, and the
  // full-step corner walk. Everything else comes from the model below.
  localparam tick_row_t TICK_TABLE [DIR_ROWS] = '{
    '{1'b0, 8'd5,   1'b0, 1'b1, {24'h050505, 24'h050000, 24'h050500, 24'h000500}},
    '{1'b0, 8'd5,   1'b1, 1'b1, {24'h050505, 24'h050000, 24'h050500, 24'h000500}},
    '{1'b1, 8'd0,   1'b0, 1'b0, NO_COLOURS},
    '{1'b0, 8'd0,   1'b1, 1'b1, {24'h000000, 24'h000000, 24'h000000, 24'h000000}},
    '{1'b1, 8'd255, 1'b1, 1'b1, {24'hFFFFFF, 24'hFF0000, 24'hFFFF00, 24'h00FF00}},
    '{1'b0, 8'd255, 1'b0, 1'b1, {24'hFFFFFF, 24'hFF0000, 24'hFFFF00, 24'h00FF00}},
    '{1'b0, 8'd255, 1'b0, 1'b1, {24'hFF0000, 24'hFFFF00, 24'h00FF00, 24'h00FFFF}},
    '{1'b0, 8'd255, 1'b0, 1'b0, NO_COLOURS},
    '{1'b0, 8'd255, 1'b0, 1'b0, NO_COLOURS},
    '{1'b0, 8'd255, 1'b0, 1'b0, NO_COLOURS},
    '{1'b0, 8'd255, 1'b0, 1'b0, NO_COLOURS},
    '{1'b0, 8'd255, 1'b0, 1'b0, NO_COLOURS},
    '{1'b0, 8'd255, 1'b0, 1'b0, NO_COLOURS},
    '{1'b0, 8'd255, 1'b0, 1'b0, NO_COLOURS},
    '{1'b0, 8'd255, 1'b0, 1'b0, NO_COLOURS},
    '{1'b0, 8'd255, 1'b0, 1'b0, NO_COLOURS},
    '{1'b0, 8'd255, 1'b0, 1'b0, NO_COLOURS},
    '{1'b0, 8'd255, 1'b0, 1'b0, NO_COLOURS},
    '{1'b0, 8'd255, 1'b0, 1'b0, NO_COLOURS},
    '{1'b0, 8'd255, 1'b0, 1'b0, NO_COLOURS},
    '{1'b1, 8'd1,   1'b1, 1'b1, {24'h010101, 24'h010000, 24'h010100, 24'h000100}},
    '{1'b1, 8'd128, 1'b0, 1'b0, NO_COLOURS},
    '{1'b0, 8'd128, 1'b0, 1'b0, NO_COLOURS},
    '{1'b1, 8'd254, 1'b0, 1'b0, NO_COLOURS},
    '{1'b0, 8'd254, 1'b1, 1'b0, NO_COLOURS}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_restart;
  logic              out_valid;
  logic              out_stall;
  logic [IDX_W-1:0]  out_led_index;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic              out_last;
  logic              cfg_wr_en;
  logic [CHAN_W-1:0] cfg_fade_step;

  // model state: phase and {r,g,b} level per LED, plus the fade step
  logic [PH_W-1:0]   fade_phase [N_LEDS];
  logic [CHAN_W-1:0] fade_level [N_LEDS][3];
  logic [CHAN_W-1:0] fade_step_now;
  led_colour_t       tick_colours [N_LEDS];
  led_colour_t       pending_colours [$];

  int ticks_sent;
  int results_seen;
  int fail_count;

  led_rainbow_fade_sequencer_unit #(.NUM_LEDS(N_LEDS)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_led_index (out_led_index),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_last      (out_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_fade_step (cfg_fade_step)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Fade model
  // -------------------------------------------------------------------------

  // corner of a phase as {red, green, blue}, 1 = full scale
  function automatic logic [2:0] corner_of(input logic [PH_W-1:0] ph);
    case (ph)
      PH_WHITE:     return 3'b111;
      PH_RED:       return 3'b100;
      PH_YELLOW:    return 3'b110;
      PH_GREEN:     return 3'b010;
      PH_TURQUOISE: return 3'b011;
      PH_BLUE:      return 3'b001;
      PH_INDIGO:    return 3'b101;
      default:      return 3'b000;
    endcase
  endfunction

  // one channel toward full scale or zero, clamped at both ends
  function automatic logic [CHAN_W-1:0] slide_level(input logic [CHAN_W-1:0] lvl,
                                                    input logic              up,
                                                    input logic [CHAN_W-1:0] amt);
    logic [CHAN_W:0] sum;
    sum = {1'b0, lvl} + {1'b0, amt};
    if (up)
      return sum[CHAN_W] ? 8'hFF : sum[CHAN_W-1:0];
    return (lvl > amt) ? lvl - amt : 8'h00;
  endfunction

  // restart: colours to black, phase = LED index mod 7
  function automatic void restart_leds();
    for (int i = 0; i < N_LEDS; i++) begin
      fade_phase[i] = PH_W'(i % 7);
      for (int c = 0; c < 3; c++)
        fade_level[i][c] = '0;
    end
  endfunction

  // one update tick over all LEDs; fills tick_colours
  function automatic void fade_tick(input logic restart);
    logic [2:0] tgt;
    logic       at_corner;
    if (restart)
      restart_leds();
    for (int i = 0; i < N_LEDS; i++) begin
      tgt = corner_of(fade_phase[i]);
      if (fade_phase[i] > PH_INDIGO) begin
        // code outside the seven phases falls back to white, colour kept
        fade_phase[i] = PH_WHITE;
      end else begin
        at_corner = 1'b1;
        for (int c = 0; c < 3; c++)
          if (fade_level[i][c] != (tgt[2-c] ? 8'hFF : 8'h00))
            at_corner = 1'b0;
        if (at_corner) begin
          // corner reached: next phase this tick, colour held
          fade_phase[i] = (fade_phase[i] == PH_INDIGO) ? PH_WHITE : fade_phase[i] + 3'd1;
        end else begin
          for (int c = 0; c < 3; c++)
            fade_level[i][c] = slide_level(fade_level[i][c], tgt[2-c], fade_step_now);
        end
      end
      tick_colours[i].led   = IDX_W'(i);
      tick_colours[i].red   = fade_level[i][0];
      tick_colours[i].green = fade_level[i][1];
      tick_colours[i].blue  = fade_level[i][2];
      tick_colours[i].last  = (i == N_LEDS - 1);
    end
  endfunction

  // -------------------------------------------------------------------------
  // Tick sender
  // -------------------------------------------------------------------------

  // Offer one tick and hold it until taken. On acceptance the model runs and
  // the expected colours are queued; typed rows replace the model's levels.
  task automatic send_tick(input logic restart, input bit typed,
                           input logic [N_LEDS*COL_W-1:0] typed_cols);
    led_colour_t c;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall !== 1'b0)
      @(posedge clk);
    fade_tick(restart);
    for (int i = 0; i < N_LEDS; i++) begin
      c = tick_colours[i];
      if (typed)
        {c.red, c.green, c.blue} = typed_cols[(N_LEDS-1-i)*COL_W +: COL_W];
      pending_colours.push_back(c);
    end
    ticks_sent++;
  endtask

  // gap after a tick: mostly none, some short, a few long
  task automatic pause_sender(input bit gaps_on);
    int gap;
    int pick;
    pick = $urandom_range(0, 15);
    gap  = (!gaps_on || pick < 10) ? 0 :
           (pick < 15) ? $urandom_range(1, 3) : $urandom_range(10, 30);
    if (gap > 0) begin
      @(negedge clk);
      in_valid   <= 1'b0;
      in_restart <= 1'($urandom_range(0, 1));  // don't-care while idle
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop offering and wait until every queued colour has come back
  task automatic settle();
    if (in_valid) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    while (pending_colours.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_fade_step(input logic [CHAN_W-1:0] v);
    @(negedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_fade_step <= v;
    @(negedge clk);
    cfg_wr_en     <= 1'b0;
    cfg_fade_step <= CHAN_W'($urandom_range(0, 255));
    fade_step_now = v;
  endtask

  // zero and full step show up regularly; most phases use a mid-to-large
  // step so the LEDs actually reach their corners and walk the phases
  function automatic logic [CHAN_W-1:0] pick_fade_step();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd1;
      3:       return CHAN_W'($urandom_range(2, 15));
      default: return CHAN_W'($urandom_range(16, 254));
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    logic [CHAN_W-1:0] step;
    int                n_ticks;
    bit                gaps_on;
    in_valid      = 1'b0;
    in_restart    = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_fade_step = '0;
    rst_n         = 1'b0;
    ticks_sent    = 0;
    restart_leds();
    fade_step_now = FADE_STEP_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table; step writes only with the block drained
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (TICK_TABLE[r].set_step) begin
        settle();
        write_fade_step(TICK_TABLE[r].step);
      end
      send_tick(TICK_TABLE[r].restart, TICK_TABLE[r].typed, TICK_TABLE[r].colours);
      pause_sender(1'b1);
    end

    // random phases: new fade step each phase, rare restarts; some phases
    // run back to back with no sender gaps
    while (ticks_sent < DIR_ROWS + RANDOM_TICKS) begin
      settle();
      step = pick_fade_step();
      write_fade_step(step);
      n_ticks = $urandom_range(30, 60);
      if (n_ticks > DIR_ROWS + RANDOM_TICKS - ticks_sent)
        n_ticks = DIR_ROWS + RANDOM_TICKS - ticks_sent;
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (n_ticks) begin
        send_tick($urandom_range(0, 24) == 0, 1'b0, NO_COLOURS);
        pause_sender(gaps_on);
      end
    end

    settle();
    // catch any stray colour after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Result side: random stalls in stretches of changing intensity, and one
  // long hold while the sender keeps offering so the block backs up.
  // -------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    int run_left;
    int mode;
    bit held;
    out_stall  = 1'b0;
    stall_left = 0;
    run_left   = 0;
    mode       = 0;
    held       = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AT_RESULT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        // mode 0: never stall, 1: light, 2: heavy
        if (run_left == 0) begin
          mode     = $urandom_range(0, 2);
          run_left = $urandom_range(20, 120);
        end
        run_left--;
        if (stall_left == 0 && mode != 0 && $urandom_range(0, (mode == 1) ? 7 : 2) == 0)
          stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
        out_stall <= (stall_left != 0);
        if (stall_left != 0)
          stall_left--;
      end
    end
  end

  // compare each colour transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    led_colour_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (pending_colours.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected colour: led %0d rgb %02h%02h%02h last %0b",
                   out_led_index, out_red, out_green, out_blue, out_last);
      end else begin
        want = pending_colours.pop_front();
        if (out_led_index !== want.led || out_red !== want.red ||
            out_green !== want.green || out_blue !== want.blue ||
            out_last !== want.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("colour mismatch: exp led %0d rgb %02h%02h%02h last %0b,",
                     want.led, want.red, want.green, want.blue, want.last,
                     " got led %0d rgb %02h%02h%02h last %0b",
                     out_led_index, out_red, out_green, out_blue, out_last);
        end
      end
    end
  end

  initial begin
    results_seen = 0;
    fail_count   = 0;
  end

  // watchdog: too many cycles with no transaction on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
